FILE: hw/rtl/itsp_pkg.sv
// shared types and constants for the iso time string parser
// no dependencies
`default_nettype none

package itsp_pkg;

  // one input transaction: a text byte or the end marker
  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_end;
  } in_t;

  // one result transaction
  typedef struct packed {
    logic [1:0] parse_status;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millisecond;
    logic [9:0] microsecond;
    logic [9:0] nanosecond;
  } res_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic       is_end;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_colon;
    logic       is_sep;
    logic       is_zone;
    logic       is_marker;
  } cls_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_T_UP  = 8'h54;
  localparam logic [7:0] CH_T_LO  = 8'h74;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;
  localparam logic [7:0] CH_Z_LO  = 8'h7A;

  localparam logic [3:0] PH_HOUR0   = 4'd0;
  localparam logic [3:0] PH_HOUR1   = 4'd1;
  localparam logic [3:0] PH_HOUR_SEP = 4'd2;
  localparam logic [3:0] PH_MIN0    = 4'd3;
  localparam logic [3:0] PH_MIN1    = 4'd4;
  localparam logic [3:0] PH_MIN_SEP = 4'd5;
  localparam logic [3:0] PH_SEC0    = 4'd6;
  localparam logic [3:0] PH_SEC1    = 4'd7;
  localparam logic [3:0] PH_SEC_SEP = 4'd8;
  localparam logic [3:0] PH_FRAC    = 4'd9;
  localparam logic [3:0] PH_DONE_OK = 4'd10;
  localparam logic [3:0] PH_NO_HOUR = 4'd11;
  localparam logic [3:0] PH_ZONE    = 4'd12;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_HOUR = 2'd1;
  localparam logic [1:0] ST_ZONE    = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam logic [6:0] MAX_HOUR    = 7'd23;
  localparam logic [6:0] MAX_MIN_SEC = 7'd59;
  localparam logic [3:0] FRAC_DIGITS = 4'd9;

endpackage

`default_nettype wire

FILE: hw/rtl/itsp_fifo.sv
// small register queue used between the parser stages
// no dependencies
`default_nettype none

module itsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/itsp_front.sv
// front end: accepts input transactions, classifies each byte, queues it
// depends on itsp_pkg and itsp_fifo
`default_nettype none

module itsp_front
  import itsp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  input  wire in_t  in_item,
  output logic      in_full,
  output cls_t      cls_item,
  output logic      cls_empty,
  input  wire logic cls_pop
);

  cls_t       cls_in;
  logic [7:0] b;

  assign b = in_item.text_byte;

  // an end item classifies like a zero byte
  always_comb begin
    cls_in           = '0;
    cls_in.is_end    = in_item.string_end;
    if (!in_item.string_end) begin
      cls_in.is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
      cls_in.digit     = cls_in.is_digit ? b[3:0] : 4'd0;
      cls_in.is_colon  = (b == CH_COLON);
      cls_in.is_sep    = (b == CH_DOT) || (b == CH_COMMA);
      cls_in.is_zone   = (b == CH_Z_UP) || (b == CH_Z_LO);
      cls_in.is_marker = (b == CH_T_UP) || (b == CH_T_LO);
    end
  end

  itsp_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (DEPTH)
  ) u_cls_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cls_in),
    .full  (in_full),
    .pop   (cls_pop),
    .rdata (cls_item),
    .empty (cls_empty)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/itsp_back.sv
// back end: parse state machine, end-of-string snapshot, result formatting
// depends on itsp_pkg and itsp_fifo
`default_nettype none

module itsp_back
  import itsp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cls_t cls_item,
  input  wire logic cls_empty,
  output logic      cls_pop,
  output res_t      out_item,
  output logic      out_empty,
  input  wire logic out_pop
);

  logic        seen_r, seen_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  min_r, min_nxt;
  logic [6:0]  sec_r, sec_nxt;
  logic [35:0] frac_r, frac_nxt;
  logic [3:0]  fcnt_r, fcnt_nxt;

  logic        snap_vld_r, snap_vld_nxt;
  logic [3:0]  snap_phase_r;
  logic [6:0]  snap_hour_r, snap_min_r, snap_sec_r;
  logic [35:0] snap_frac_r;

  logic        take, snap_free, out_full, res_push, do_snap;
  logic [6:0]  d_x10;
  res_t        res;

  function automatic logic [9:0] frac_group(input logic [11:0] bcd);
    logic [9:0] d0, d1, d2;
    d0 = {6'd0, bcd[11:8]};
    d1 = {6'd0, bcd[7:4]};
    d2 = {6'd0, bcd[3:0]};
    return d0 * 10'd100 + d1 * 10'd10 + d2;
  endfunction

  // phase reached by feeding an end item (never a digit, marker or zone)
  function automatic logic [3:0] phase_nxt_pre(input logic [3:0] ph, input cls_t c);
    logic [3:0] p;
    p = ph;
    if (c.is_end) begin
      if (ph == PH_HOUR0 || ph == PH_HOUR1) begin
        p = PH_NO_HOUR;
      end else if (ph <= PH_FRAC) begin
        p = PH_DONE_OK;
      end
    end
    return p;
  endfunction

  assign snap_free = !snap_vld_r || !out_full;
  assign take      = !cls_empty && (!cls_item.is_end || snap_free);
  assign cls_pop   = take;
  assign do_snap   = take && cls_item.is_end;
  assign d_x10     = {cls_item.digit, 3'b000} + {2'b00, cls_item.digit, 1'b0};

  always_comb begin
    seen_nxt  = seen_r;
    phase_nxt = phase_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    frac_nxt  = frac_r;
    fcnt_nxt  = fcnt_r;
    if (take) begin
      if (!seen_r && cls_item.is_marker) begin
        // first time marker restarts the parse
        seen_nxt  = 1'b1;
        phase_nxt = PH_HOUR0;
        hour_nxt  = '0;
        min_nxt   = '0;
        sec_nxt   = '0;
        frac_nxt  = '0;
        fcnt_nxt  = '0;
      end else begin
        unique case (phase_r)
          PH_HOUR0: begin
            if (cls_item.is_digit) begin
              hour_nxt  = d_x10;
              phase_nxt = PH_HOUR1;
            end else begin
              hour_nxt  = '0;
              phase_nxt = PH_NO_HOUR;
            end
          end
          PH_HOUR1: begin
            if (cls_item.is_digit) begin
              hour_nxt  = hour_r + {3'd0, cls_item.digit};
              phase_nxt = PH_HOUR_SEP;
            end else begin
              hour_nxt  = '0;
              phase_nxt = PH_NO_HOUR;
            end
          end
          PH_HOUR_SEP, PH_MIN0: begin
            if (phase_r == PH_HOUR_SEP && cls_item.is_colon) begin
              phase_nxt = PH_MIN0;
            end else if (cls_item.is_digit) begin
              min_nxt   = d_x10;
              phase_nxt = PH_MIN1;
            end else begin
              phase_nxt = cls_item.is_zone ? PH_ZONE : PH_DONE_OK;
            end
          end
          PH_MIN1: begin
            if (cls_item.is_digit) begin
              min_nxt   = min_r + {3'd0, cls_item.digit};
              phase_nxt = PH_MIN_SEP;
            end else begin
              // half a pair counts as absent
              min_nxt   = '0;
              phase_nxt = PH_DONE_OK;
            end
          end
          PH_MIN_SEP, PH_SEC0: begin
            if (phase_r == PH_MIN_SEP && cls_item.is_colon) begin
              phase_nxt = PH_SEC0;
            end else if (cls_item.is_digit) begin
              sec_nxt   = d_x10;
              phase_nxt = PH_SEC1;
            end else begin
              phase_nxt = cls_item.is_zone ? PH_ZONE : PH_DONE_OK;
            end
          end
          PH_SEC1: begin
            if (cls_item.is_digit) begin
              sec_nxt   = sec_r + {3'd0, cls_item.digit};
              phase_nxt = PH_SEC_SEP;
            end else begin
              sec_nxt   = '0;
              phase_nxt = PH_DONE_OK;
            end
          end
          PH_SEC_SEP: begin
            if (cls_item.is_sep) begin
              phase_nxt = PH_FRAC;
            end else begin
              phase_nxt = cls_item.is_zone ? PH_ZONE : PH_DONE_OK;
            end
          end
          PH_FRAC: begin
            if (cls_item.is_digit) begin
              if (fcnt_r < FRAC_DIGITS) begin
                // first fraction digit lands in the top nibble
                for (int i = 0; i < 9; i++) begin
                  if (fcnt_r == 4'(i)) begin
                    frac_nxt[4*(8-i) +: 4] = cls_item.digit;
                  end
                end
                fcnt_nxt = fcnt_r + 4'd1;
              end
            end else begin
              phase_nxt = cls_item.is_zone ? PH_ZONE : PH_DONE_OK;
            end
          end
          default: begin
          end
        endcase
      end
      if (cls_item.is_end) begin
        seen_nxt  = 1'b0;
        phase_nxt = PH_HOUR0;
        hour_nxt  = '0;
        min_nxt   = '0;
        sec_nxt   = '0;
        frac_nxt  = '0;
        fcnt_nxt  = '0;
      end
    end
  end

  // snapshot takes the state as it stands after the end item
  assign snap_vld_nxt = (snap_vld_r && out_full) || do_snap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= 1'b0;
      phase_r    <= PH_HOUR0;
      hour_r     <= '0;
      min_r      <= '0;
      sec_r      <= '0;
      frac_r     <= '0;
      fcnt_r     <= '0;
      snap_vld_r <= 1'b0;
    end else begin
      seen_r     <= seen_nxt;
      phase_r    <= phase_nxt;
      hour_r     <= hour_nxt;
      min_r      <= min_nxt;
      sec_r      <= sec_nxt;
      frac_r     <= frac_nxt;
      fcnt_r     <= fcnt_nxt;
      snap_vld_r <= snap_vld_nxt;
    end
  end

  // end handling moves the pre-reset values; the end item itself forces any
  // running phase to a stop, which the same case logic already did
  always_ff @(posedge clk) begin
    if (do_snap) begin
      snap_phase_r <= phase_nxt_pre(phase_r, cls_item);
      snap_hour_r  <= (phase_r == PH_HOUR1) ? 7'd0 : hour_r;
      snap_min_r   <= (phase_r == PH_MIN1) ? 7'd0 : min_r;
      snap_sec_r   <= (phase_r == PH_SEC1) ? 7'd0 : sec_r;
      snap_frac_r  <= frac_r;
    end
  end

  always_comb begin
    res = '0;
    if (snap_phase_r == PH_NO_HOUR || snap_phase_r < PH_HOUR_SEP) begin
      res.parse_status = ST_NO_HOUR;
    end else if (snap_phase_r == PH_ZONE) begin
      res.parse_status = ST_ZONE;
    end else if (snap_hour_r > MAX_HOUR || snap_min_r > MAX_MIN_SEC ||
                 snap_sec_r > MAX_MIN_SEC) begin
      res.parse_status = ST_RANGE;
    end else begin
      res.parse_status = ST_OK;
      res.hour         = snap_hour_r[4:0];
      res.minute       = snap_min_r[5:0];
      res.second       = snap_sec_r[5:0];
      res.millisecond  = frac_group(snap_frac_r[35:24]);
      res.microsecond  = frac_group(snap_frac_r[23:12]);
      res.nanosecond   = frac_group(snap_frac_r[11:0]);
    end
  end

  assign res_push = snap_vld_r && !out_full;

  itsp_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/iso_time_string_parser.sv
// iso 8601 time-of-day parser, one text byte per transaction
// throughput: one byte or end transaction per clock while neither queue is full
// a result shows on the out ports after its end transaction passes the byte queue, the
// snapshot register and the result queue in that order, and can be popped from there
// reset: synchronous active-low rst_n empties both queues and returns the parse to its start
// depends on itsp_pkg, itsp_front, itsp_back
`default_nettype none

module iso_time_string_parser
  import itsp_pkg::*;
#(
  parameter int CLS_DEPTH = 4,
  parameter int RES_DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  input  wire in_t  in_item,
  output logic      in_full,
  output logic      out_empty,
  input  wire logic out_pop,
  output res_t      out_item
);

  cls_t cls_item;
  logic cls_empty;
  logic cls_pop;

  itsp_front #(
    .DEPTH (CLS_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cls_item  (cls_item),
    .cls_empty (cls_empty),
    .cls_pop   (cls_pop)
  );

  itsp_back #(
    .DEPTH (RES_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_item  (cls_item),
    .cls_empty (cls_empty),
    .cls_pop   (cls_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

`default_nettype wire

FILE: bench/iso_time_string_parser_test.sv
// self-checking bench for iso_time_string_parser: directed and random time strings
// with a scoreboard that parses each byte alongside the block
// depends on itsp_pkg and the iso_time_string_parser rtl
module iso_time_string_parser_test
  import itsp_pkg::*;
;

  // tracks the parse of the string in flight and holds results still owed
  class iso_time_scoreboard;
    logic        marker_seen;
    logic [3:0]  phase;
    logic [6:0]  hour_val;
    logic [6:0]  min_val;
    logic [6:0]  sec_val;
    logic [35:0] frac_nibbles;
    logic [3:0]  frac_cnt;
    res_t        expected_times[$];
    int          errors;

    function new();
      marker_seen = 1'b0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_HOUR0;
      hour_val = '0;
      min_val = '0;
      sec_val = '0;
      frac_nibbles = '0;
      frac_cnt = '0;
    endfunction

    function void parse_byte(logic [7:0] c);
      logic       is_dig;
      logic       is_zone;
      logic [6:0] d;
      is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
      d = is_dig ? 7'(c - CH_ZERO) : 7'd0;
      is_zone = (c == CH_Z_UP) || (c == CH_Z_LO);
      // only the first marker restarts, even after a stop
      if (!marker_seen && (c == CH_T_UP || c == CH_T_LO)) begin
        restart();
        marker_seen = 1'b1;
        return;
      end
      case (phase)
        PH_HOUR0: begin
          if (is_dig) begin
            hour_val = 7'(d * 10);
            phase = PH_HOUR1;
          end else begin
            hour_val = '0;
            phase = PH_NO_HOUR;
          end
        end
        PH_HOUR1: begin
          if (is_dig) begin
            hour_val = hour_val + d;
            phase = PH_HOUR_SEP;
          end else begin
            hour_val = '0;
            phase = PH_NO_HOUR;
          end
        end
        PH_HOUR_SEP, PH_MIN0: begin
          if (phase == PH_HOUR_SEP && c == CH_COLON) phase = PH_MIN0;
          else if (is_dig) begin
            min_val = 7'(d * 10);
            phase = PH_MIN1;
          end else phase = is_zone ? PH_ZONE : PH_DONE_OK;
        end
        PH_MIN1: begin
          if (is_dig) begin
            min_val = min_val + d;
            phase = PH_MIN_SEP;
          end else begin
            min_val = '0;
            phase = PH_DONE_OK;
          end
        end
        PH_MIN_SEP, PH_SEC0: begin
          if (phase == PH_MIN_SEP && c == CH_COLON) phase = PH_SEC0;
          else if (is_dig) begin
            sec_val = 7'(d * 10);
            phase = PH_SEC1;
          end else phase = is_zone ? PH_ZONE : PH_DONE_OK;
        end
        PH_SEC1: begin
          if (is_dig) begin
            sec_val = sec_val + d;
            phase = PH_SEC_SEP;
          end else begin
            sec_val = '0;
            phase = PH_DONE_OK;
          end
        end
        PH_SEC_SEP: begin
          if (c == CH_DOT || c == CH_COMMA) phase = PH_FRAC;
          else phase = is_zone ? PH_ZONE : PH_DONE_OK;
        end
        PH_FRAC: begin
          if (is_dig) begin
            // digits past the ninth are dropped
            if (frac_cnt < FRAC_DIGITS) begin
              frac_nibbles = frac_nibbles | (36'(d[3:0]) << (4 * (8 - frac_cnt)));
              frac_cnt = frac_cnt + 4'd1;
            end
          end else phase = is_zone ? PH_ZONE : PH_DONE_OK;
        end
        default: ;
      endcase
    endfunction

    function logic [9:0] frac_group(int first);
      int v;
      v = 100 * frac_nibbles[4 * (8 - first) +: 4] + 10 * frac_nibbles[4 * (7 - first) +: 4]
          + frac_nibbles[4 * (6 - first) +: 4];
      return 10'(v);
    endfunction

    function void accept_item(in_t it);
      res_t r;
      if (!it.string_end) begin
        parse_byte(it.text_byte);
        return;
      end
      // the end transaction closes the parse like a non-zone stray byte
      parse_byte(8'h00);
      r = '0;
      if (phase == PH_NO_HOUR || phase < PH_HOUR_SEP) r.parse_status = ST_NO_HOUR;
      else if (phase == PH_ZONE) r.parse_status = ST_ZONE;
      else if (hour_val > MAX_HOUR || min_val > MAX_MIN_SEC || sec_val > MAX_MIN_SEC)
        r.parse_status = ST_RANGE;
      else r.parse_status = ST_OK;
      if (r.parse_status == ST_OK) begin
        r.hour = hour_val[4:0];
        r.minute = min_val[5:0];
        r.second = sec_val[5:0];
        r.millisecond = frac_group(0);
        r.microsecond = frac_group(3);
        r.nanosecond = frac_group(6);
      end
      expected_times.push_back(r);
      marker_seen = 1'b0;
      restart();
    endfunction

    function void compare_field(string field, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, field, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (expected_times.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        errors++;
        return;
      end
      exp_r = expected_times.pop_front();
      compare_field("parse_status", int'(exp_r.parse_status), int'(got.parse_status));
      compare_field("hour", int'(exp_r.hour), int'(got.hour));
      compare_field("minute", int'(exp_r.minute), int'(got.minute));
      compare_field("second", int'(exp_r.second), int'(got.second));
      compare_field("millisecond", int'(exp_r.millisecond), int'(got.millisecond));
      compare_field("microsecond", int'(exp_r.microsecond), int'(got.microsecond));
      compare_field("nanosecond", int'(exp_r.nanosecond), int'(got.nanosecond));
    endfunction

    function int pending();
      return expected_times.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  in_t  in_item;
  logic in_full;
  logic out_empty;
  logic out_pop;
  res_t out_item;

  iso_time_scoreboard sb;
  int in_idle_pct;
  int out_idle_pct;
  int items_pushed;

  string directed_cases[] = '{
    "00:00:00", "23:59:59.999999999999", "235959", "12:34:56,123456789",
    "07:08:09.1", "24:00", "12:60", "12:00:60", "99", "1", "", "12Z",
    "12:34z", "08:30:15.25Z", "2024-05-06T10:20:30.5", "xxT12tZ", "12:3x",
    "12:34:5", "abT08:15", "12:34:56.", "tT11", "12::30"
  };

  iso_time_string_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // called at a falling edge, returns at a falling edge after the transaction
  task automatic send_item(in_t it);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_full);
    sb.accept_item(it);
    items_pushed++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    in_t it;
    it.text_byte = b;
    it.string_end = 1'b0;
    send_item(it);
  endtask

  task automatic send_end();
    in_t it;
    it.text_byte = 8'($urandom_range(1, 255));
    it.string_end = 1'b1;
    send_item(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_end();
  endtask

  function automatic logic [7:0] digit_char(int v);
    return CH_ZERO + 8'(v);
  endfunction

  // two digits, mostly in range, now and then only one
  function automatic void add_pair(ref logic [7:0] q[$], input int top);
    int v;
    v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, top);
    q.push_back(digit_char(v / 10));
    if ($urandom_range(0, 19) != 0) q.push_back(digit_char(v % 10));
  endfunction

  task automatic send_random_string();
    logic [7:0] txt[$];
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(0, 10)) txt.push_back(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 6))
          txt.push_back(($urandom_range(0, 3) == 0) ? 8'h2D : digit_char($urandom_range(0, 9)));
      if ($urandom_range(0, 2) != 0)
        txt.push_back($urandom_range(0, 1) ? CH_T_UP : CH_T_LO);
      add_pair(txt, 23);
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 3) != 0) txt.push_back(CH_COLON);
        add_pair(txt, 59);
        if ($urandom_range(0, 9) != 0) begin
          if ($urandom_range(0, 3) != 0) txt.push_back(CH_COLON);
          add_pair(txt, 59);
          if ($urandom_range(0, 2) != 0) begin
            txt.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
            repeat ($urandom_range(0, 12)) txt.push_back(digit_char($urandom_range(0, 9)));
          end
        end
      end
      case ($urandom_range(0, 7))
        0: txt.push_back(CH_Z_UP);
        1: txt.push_back(CH_Z_LO);
        2: txt.push_back($urandom_range(0, 1) ? CH_T_UP : CH_T_LO);
        3: txt.push_back(8'($urandom_range(1, 255)));
        default: ;
      endcase
    end
    foreach (txt[i]) send_byte(txt[i]);
    send_end();
  endtask

  task automatic wait_drained();
    in_push = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop = rst_n && ($urandom_range(0, 99) >= out_idle_pct);
      @(posedge clk);
      if (out_pop && !out_empty) sb.check_result(out_item);
    end
  end

  initial begin
    #(12 * 400000);
    $display("FAIL iso_time_string_parser");
    $finish;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    in_idle_pct = 17;
    out_idle_pct = 67;
    items_pushed = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_cases[i]) send_text(directed_cases[i]);
    // stray high and low byte values before a time, and after a marker
    send_byte(8'hFF);
    send_text("12");
    send_byte(CH_T_UP);
    send_byte(8'h80);
    send_byte(8'h01);
    send_end();

    while (items_pushed < 200) send_random_string();
    wait_drained();

    in_idle_pct = 67;
    out_idle_pct = 17;
    while (items_pushed < 350) send_random_string();
    wait_drained();

    in_idle_pct = 0;
    out_idle_pct = 0;
    while (items_pushed < 500) send_random_string();
    wait_drained();

    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("PASS iso_time_string_parser");
    else $display("FAIL iso_time_string_parser");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/itsp_pkg.sv
hw/rtl/itsp_fifo.sv
hw/rtl/itsp_front.sv
hw/rtl/itsp_back.sv
hw/rtl/iso_time_string_parser.sv
bench/iso_time_string_parser_test.sv
